FILE: src/efr_pkg.sv
// -----------------------------------------------------------------------------
// efr_pkg - shared types and constants for the Euler frame rotation block
// Sample and angle types, register indexes, CORDIC arctangent table and the
// 24-bit output saturation helper.
// -----------------------------------------------------------------------------
package efr_pkg;

   // Widths fixed by the item fields
   localparam int SAMPLE_W = 24;
   localparam int ANGLE_W  = 16;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ANGLE_W-1:0]  angle_type;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_ROLL  = 2'd0,
      REG_PITCH = 2'd1,
      REG_YAW   = 2'd2
   } reg_idx_type;

   localparam int NUM_ANGLES = 3;

   // CORDIC: 30 micro-rotations, gain-compensated start value in Q30
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10680862,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41721,
      30'd20860,     30'd10430,     30'd5215,      30'd2607,     30'd1303,
      30'd651,       30'd325,       30'd162,       30'd81,       30'd40,
      30'd20,        30'd10,        30'd5,         30'd2,        30'd1
   };

   // Quotient bits kept by the divider; anything larger always clips
   localparam int QUO_BITS = 25;

   localparam sample_type OUT_MAX = 24'sh7FFFFF;
   localparam sample_type OUT_MIN = 24'sh800000;

   typedef struct packed {
      sample_type value;
      logic       clip;
   } sat_type;

   // Clip a value to the 24-bit output range
   function automatic sat_type sat24(input logic signed [31:0] v);
      sat_type r;
      if (v > 32'sd8388607) begin
         r.value = OUT_MAX;
         r.clip  = 1'b1;
      end else if (v < -32'sd8388608) begin
         r.value = OUT_MIN;
         r.clip  = 1'b1;
      end else begin
         r.value = v[SAMPLE_W-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: src/efr_coef.sv
// -----------------------------------------------------------------------------
// efr_coef - trig coefficient and rotation matrix generator
// Runs a shared iterative CORDIC over roll, pitch and yaw, then forms the
// nine direction cosine entries from fourteen products on one multiplier.
// -----------------------------------------------------------------------------
module efr_coef #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  efr_pkg::angle_type       roll,
   input  efr_pkg::angle_type       pitch,
   input  efr_pkg::angle_type       yaw,
   output logic                     busy,
   output logic signed [FRAC_BITS+1:0] sin_roll,
   output logic signed [FRAC_BITS+1:0] cos_roll,
   output logic signed [FRAC_BITS+1:0] sin_pitch,
   output logic signed [FRAC_BITS+1:0] cos_pitch,
   output logic signed [FRAC_BITS+2:0] mat [9]
);
   import efr_pkg::*;

   localparam int CW        = FRAC_BITS + 2;
   localparam int MW        = FRAC_BITS + 3;
   localparam int PW        = 2 * CW;
   localparam int CSH       = 30 - FRAC_BITS;
   localparam longint CRD   = (CSH > 0) ? (longint'(1) << (CSH - 1)) : longint'(0);
   localparam longint FRND  = longint'(1) << (FRAC_BITS - 1);
   localparam int MUL_STEPS = 14;
   localparam logic [4:0] ROT_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic [4:0] MUL_LAST = 5'(MUL_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROT,
      ST_STORE,
      ST_MUL,
      ST_MAT
   } state_type;

   state_type                   state_ff;
   logic [1:0]                  ang_idx_ff;
   logic [4:0]                  step_ff;
   logic signed [CORDIC_W-1:0]  x_ff, y_ff, z_ff;
   logic                        neg_ff;
   logic signed [CW-1:0]        sin_ff [NUM_ANGLES];
   logic signed [CW-1:0]        cos_ff [NUM_ANGLES];
   logic signed [PW-1:0]        prod_ff;
   logic signed [CW-1:0]        p_ff [MUL_STEPS];
   logic signed [MW-1:0]        mat_ff [9];

   angle_type                   ang_sel;
   logic signed [CORDIC_W-1:0]  z_fold;
   logic                        neg_fold;
   logic signed [CORDIC_W-1:0]  x_sh, y_sh, atan_val;
   logic signed [CORDIC_W-1:0]  x_in, y_in, z_in;
   logic signed [CORDIC_W-1:0]  x_fin, y_fin, x_rnd, y_rnd;
   logic signed [CW-1:0]        op_a, op_b;
   logic signed [PW-1:0]        prod_rnd;

   // Select the angle and fold it into the CORDIC range
   always_comb begin
      unique case (reg_idx_type'(ang_idx_ff))
         REG_ROLL:  ang_sel = roll;
         REG_PITCH: ang_sel = pitch;
         REG_YAW:   ang_sel = yaw;
         default:   ang_sel = yaw;
      endcase
      z_fold   = {{2{ang_sel[ANGLE_W-1]}}, ang_sel, 16'b0};
      neg_fold = 1'b0;
      if (z_fold > 34'sd1073741824) begin
         z_fold   = z_fold - 34'sd2147483648;
         neg_fold = 1'b1;
      end else if (z_fold < -34'sd1073741824) begin
         z_fold   = z_fold + 34'sd2147483648;
         neg_fold = 1'b1;
      end
   end

   // One micro-rotation
   always_comb begin
      x_sh     = x_ff >>> step_ff;
      y_sh     = y_ff >>> step_ff;
      atan_val = CORDIC_W'(ATAN_TAB[step_ff]);
      if (z_ff >= 0) begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
         z_in = z_ff - atan_val;
      end else begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
         z_in = z_ff + atan_val;
      end
   end

   // Undo the fold and round to the coefficient format
   always_comb begin
      x_fin = neg_ff ? -x_ff : x_ff;
      y_fin = neg_ff ? -y_ff : y_ff;
      x_rnd = (x_fin + CORDIC_W'(CRD)) >>> CSH;
      y_rnd = (y_fin + CORDIC_W'(CRD)) >>> CSH;
   end

   // Operand schedule for the matrix products
   always_comb begin
      unique case (step_ff)
         5'd0:    begin op_a = cos_ff[REG_YAW];   op_b = sin_ff[REG_PITCH]; end
         5'd1:    begin op_a = sin_ff[REG_YAW];   op_b = sin_ff[REG_PITCH]; end
         5'd2:    begin op_a = cos_ff[REG_YAW];   op_b = cos_ff[REG_PITCH]; end
         5'd3:    begin op_a = sin_ff[REG_YAW];   op_b = cos_ff[REG_PITCH]; end
         5'd4:    begin op_a = p_ff[0];           op_b = sin_ff[REG_ROLL];  end
         5'd5:    begin op_a = sin_ff[REG_YAW];   op_b = cos_ff[REG_ROLL];  end
         5'd6:    begin op_a = p_ff[1];           op_b = sin_ff[REG_ROLL];  end
         5'd7:    begin op_a = cos_ff[REG_YAW];   op_b = cos_ff[REG_ROLL];  end
         5'd8:    begin op_a = cos_ff[REG_PITCH]; op_b = sin_ff[REG_ROLL];  end
         5'd9:    begin op_a = p_ff[0];           op_b = cos_ff[REG_ROLL];  end
         5'd10:   begin op_a = sin_ff[REG_YAW];   op_b = sin_ff[REG_ROLL];  end
         5'd11:   begin op_a = p_ff[1];           op_b = cos_ff[REG_ROLL];  end
         5'd12:   begin op_a = cos_ff[REG_YAW];   op_b = sin_ff[REG_ROLL];  end
         5'd13:   begin op_a = cos_ff[REG_PITCH]; op_b = cos_ff[REG_ROLL];  end
         default: begin op_a = '0;                op_b = '0;                end
      endcase
      prod_rnd = (prod_ff + PW'(FRND)) >>> FRAC_BITS;
   end

   // Sequencer: CORDIC per angle, then products, then matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         ang_idx_ff <= 2'd0;
         step_ff    <= 5'd0;
      end else if (restart) begin
         state_ff   <= ST_LOAD;
         ang_idx_ff <= 2'd0;
         step_ff    <= 5'd0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               state_ff <= ST_IDLE;
            end
            ST_LOAD: begin
               x_ff     <= CORDIC_GAIN;
               y_ff     <= '0;
               z_ff     <= z_fold;
               neg_ff   <= neg_fold;
               step_ff  <= 5'd0;
               state_ff <= ST_ROT;
            end
            ST_ROT: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_in;
               if (step_ff == ROT_LAST) begin
                  state_ff <= ST_STORE;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_STORE: begin
               sin_ff[ang_idx_ff] <= y_rnd[CW-1:0];
               cos_ff[ang_idx_ff] <= x_rnd[CW-1:0];
               step_ff            <= 5'd0;
               if (ang_idx_ff == 2'(NUM_ANGLES - 1)) begin
                  state_ff <= ST_MUL;
               end else begin
                  ang_idx_ff <= ang_idx_ff + 2'd1;
                  state_ff   <= ST_LOAD;
               end
            end
            ST_MUL: begin
               prod_ff <= op_a * op_b;
               if (step_ff != 5'd0) begin
                  p_ff[step_ff[3:0] - 4'd1] <= prod_rnd[CW-1:0];
               end
               if (step_ff == MUL_LAST) begin
                  state_ff <= ST_MAT;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_MAT: begin
               mat_ff[0] <= MW'(p_ff[2]);
               mat_ff[1] <= MW'(p_ff[3]);
               mat_ff[2] <= -MW'(sin_ff[REG_PITCH]);
               mat_ff[3] <= MW'(p_ff[4]) - MW'(p_ff[5]);
               mat_ff[4] <= MW'(p_ff[6]) + MW'(p_ff[7]);
               mat_ff[5] <= MW'(p_ff[8]);
               mat_ff[6] <= MW'(p_ff[9]) + MW'(p_ff[10]);
               mat_ff[7] <= MW'(p_ff[11]) - MW'(p_ff[12]);
               mat_ff[8] <= MW'(p_ff[13]);
               state_ff  <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign sin_roll  = sin_ff[REG_ROLL];
   assign cos_roll  = cos_ff[REG_ROLL];
   assign sin_pitch = sin_ff[REG_PITCH];
   assign cos_pitch = cos_ff[REG_PITCH];
   assign mat       = mat_ff;

endmodule

FILE: src/efr_div.sv
// -----------------------------------------------------------------------------
// efr_div - pipelined rounding divider by the pitch cosine
// Rounds half away from zero, one quotient bit per stage, flags quotients
// too large for the QB-bit quotient.
// -----------------------------------------------------------------------------
module efr_div #(
   parameter int NW = 45,
   parameter int CW = 18,
   parameter int QB = 25
) (
   input  logic                 clock,
   input  logic signed [NW-1:0] num,
   input  logic signed [CW-1:0] den,
   output logic [QB-1:0]        quo,
   output logic                 ovf,
   output logic                 neg
);
   import efr_pkg::*;

   localparam int RW = (NW + 1 > CW + QB + 1) ? NW + 1 : CW + QB + 1;

   logic [RW-1:0] rem_ff  [QB+1];
   logic [QB-1:0] q_ff    [QB+1];
   logic          neg_ff  [QB+1];
   logic          ovf_ff  [QB+1];
   logic          zero_ff [QB+1];

   logic [NW-1:0] n_mag;
   logic [CW-1:0] d_mag;
   logic [RW-1:0] n_bias;

   // Magnitudes and the half-divisor bias
   always_comb begin
      n_mag  = num[NW-1] ? (~num + NW'(1)) : num;
      d_mag  = den[CW-1] ? (~den + CW'(1)) : den;
      n_bias = RW'(n_mag) + RW'(d_mag >> 1);
   end

   // Set up the quotient, test for out of range
   always_ff @(posedge clock) begin
      rem_ff[0]  <= n_bias;
      q_ff[0]    <= '0;
      neg_ff[0]  <= num[NW-1] ^ den[CW-1];
      zero_ff[0] <= (n_mag == '0);
      ovf_ff[0]  <= (n_mag != '0) && (n_bias >= (RW'(d_mag) << QB));
   end

   // One restoring step per stage, most significant bit first
   for (genvar k = 1; k <= QB; k++) begin : g_step
      localparam int SH = QB - k;
      logic [RW-1:0] bound;
      logic          take;
      assign bound = RW'(d_mag) << SH;
      assign take  = (rem_ff[k-1] >= bound);
      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? (rem_ff[k-1] - bound) : rem_ff[k-1];
         q_ff[k]    <= {q_ff[k-1][QB-2:0], take};
         neg_ff[k]  <= neg_ff[k-1];
         ovf_ff[k]  <= ovf_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   // A zero numerator always gives a zero term
   assign quo = zero_ff[QB] ? '0 : q_ff[QB];
   assign ovf = ovf_ff[QB];
   assign neg = neg_ff[QB];

endmodule

FILE: src/efr_pipe.sv
// -----------------------------------------------------------------------------
// efr_pipe - vector datapath
// Multiply, row sum and rescale stages for both modes, two dividers for the
// Euler rate terms, and the saturating output register.
// -----------------------------------------------------------------------------
module efr_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_mode,
   input  efr_pkg::sample_type         in_a,
   input  efr_pkg::sample_type         in_b,
   input  efr_pkg::sample_type         in_c,
   input  logic signed [FRAC_BITS+1:0] sin_roll,
   input  logic signed [FRAC_BITS+1:0] cos_roll,
   input  logic signed [FRAC_BITS+1:0] sin_pitch,
   input  logic signed [FRAC_BITS+1:0] cos_pitch,
   input  logic signed [FRAC_BITS+2:0] mat [9],
   output logic                        out_valid,
   output efr_pkg::sample_type         out_first,
   output efr_pkg::sample_type         out_second,
   output efr_pkg::sample_type         out_third,
   output logic                        out_sat
);
   import efr_pkg::*;

   localparam int CW      = FRAC_BITS + 2;
   localparam int MW      = FRAC_BITS + 3;
   localparam int PW0     = MW + SAMPLE_W;
   localparam int SW0     = PW0 + 2;
   localparam int ROW_W   = SW0 - FRAC_BITS;
   localparam int PW1     = CW + SAMPLE_W;
   localparam int SW1     = PW1 + 1;
   localparam int T_W     = SW1 - FRAC_BITS;
   localparam int NW      = T_W + CW;
   localparam int DL      = QUO_BITS + 1;
   localparam longint RND = longint'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic                    valid;
      logic                    mode;
      sample_type              a;
      logic signed [ROW_W-1:0] row0;
      logic signed [ROW_W-1:0] row1;
      logic signed [ROW_W-1:0] row2;
      logic signed [T_W-1:0]   r1m;
   } side_type;

   // Stage 1
   logic                    v1_ff, mode1_ff;
   sample_type              a1_ff;
   logic signed [PW0-1:0]   prod0_ff [9];
   logic signed [PW1-1:0]   crc_ff, srb_ff, crb_ff, src_ff;
   sample_type              xin [3];
   // Stage 2
   logic                    v2_ff, mode2_ff;
   sample_type              a2_ff;
   logic signed [ROW_W-1:0] row2_ff [3];
   logic signed [T_W-1:0]   t2_ff, r1m2_ff;
   logic signed [SW1-1:0]   n22_ff;
   logic signed [SW0-1:0]   row_sum [3];
   logic signed [SW0-1:0]   row_rnd [3];
   logic signed [SW1-1:0]   t_diff, r1_diff, t_rnd, r1_rnd;
   // Stage 3
   side_type                side3_ff;
   logic signed [NW-1:0]    n03_ff, n23_ff;
   // Divider alignment
   side_type                side_ff [DL];
   logic [QUO_BITS-1:0]     q0, q2;
   logic                    ovf0, ovf2, neg0, neg2;
   // Output
   side_type                side_o;
   logic signed [QUO_BITS+1:0] term0, term2;
   sat_type                 s0, s1, s2;
   logic                    out_valid_ff, out_sat_ff;
   sample_type              out_first_ff, out_second_ff, out_third_ff;

   assign xin[0] = in_a;
   assign xin[1] = in_b;
   assign xin[2] = in_c;

   // Stage 1: all products for both modes
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      mode1_ff <= in_mode;
      a1_ff    <= in_a;
      for (int k = 0; k < 9; k++) begin
         prod0_ff[k] <= mat[k] * xin[k % 3];
      end
      crc_ff <= cos_roll * in_c;
      srb_ff <= sin_roll * in_b;
      crb_ff <= cos_roll * in_b;
      src_ff <= sin_roll * in_c;
   end

   // Stage 2: row sums and rescale
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = SW0'(prod0_ff[3*r]) + SW0'(prod0_ff[3*r+1]) + SW0'(prod0_ff[3*r+2]);
         row_rnd[r] = (row_sum[r] + SW0'(RND)) >>> FRAC_BITS;
      end
      t_diff  = SW1'(crc_ff) - SW1'(srb_ff);
      r1_diff = SW1'(crb_ff) - SW1'(src_ff);
      t_rnd   = (t_diff + SW1'(RND)) >>> FRAC_BITS;
      r1_rnd  = (r1_diff + SW1'(RND)) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      mode2_ff <= mode1_ff;
      a2_ff    <= a1_ff;
      for (int r = 0; r < 3; r++) begin
         row2_ff[r] <= row_rnd[r][ROW_W-1:0];
      end
      t2_ff   <= t_rnd[T_W-1:0];
      r1m2_ff <= r1_rnd[T_W-1:0];
      n22_ff  <= SW1'(srb_ff) + SW1'(crc_ff);
   end

   // Stage 3: pitch tangent numerator
   always_ff @(posedge clock) begin
      if (reset) begin
         side3_ff.valid <= 1'b0;
      end else begin
         side3_ff.valid <= v2_ff;
      end
      side3_ff.mode <= mode2_ff;
      side3_ff.a    <= a2_ff;
      side3_ff.row0 <= row2_ff[0];
      side3_ff.row1 <= row2_ff[1];
      side3_ff.row2 <= row2_ff[2];
      side3_ff.r1m  <= r1m2_ff;
      n03_ff        <= t2_ff * sin_pitch;
      n23_ff        <= NW'(n22_ff);
   end

   efr_div #(.NW(NW), .CW(CW), .QB(QUO_BITS)) u_div_roll (
      .clock (clock),
      .num   (n03_ff),
      .den   (cos_pitch),
      .quo   (q0),
      .ovf   (ovf0),
      .neg   (neg0)
   );

   efr_div #(.NW(NW), .CW(CW), .QB(QUO_BITS)) u_div_yaw (
      .clock (clock),
      .num   (n23_ff),
      .den   (cos_pitch),
      .quo   (q2),
      .ovf   (ovf2),
      .neg   (neg2)
   );

   // Carry the other results alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else begin
         side_ff[0] <= side3_ff;
         for (int k = 1; k < DL; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign side_o = side_ff[DL-1];

   // Apply signs, add roll rate, saturate
   always_comb begin
      term0 = neg0 ? -$signed({2'b0, q0}) : $signed({2'b0, q0});
      term2 = neg2 ? -$signed({2'b0, q2}) : $signed({2'b0, q2});
      if (side_o.mode) begin
         if (ovf0) begin
            s0.value = neg0 ? OUT_MIN : OUT_MAX;
            s0.clip  = 1'b1;
         end else begin
            s0 = sat24(32'(side_o.a) + 32'(term0));
         end
         s1 = sat24(32'(side_o.r1m));
         if (ovf2) begin
            s2.value = neg2 ? OUT_MIN : OUT_MAX;
            s2.clip  = 1'b1;
         end else begin
            s2 = sat24(32'(term2));
         end
      end else begin
         s0 = sat24(32'(side_o.row0));
         s1 = sat24(32'(side_o.row1));
         s2 = sat24(32'(side_o.row2));
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= side_o.valid;
      end
      out_first_ff  <= s0.value;
      out_second_ff <= s1.value;
      out_third_ff  <= s2.value;
      out_sat_ff    <= s0.clip | s1.clip | s2.clip;
   end

   assign out_valid  = out_valid_ff;
   assign out_first  = out_first_ff;
   assign out_second = out_second_ff;
   assign out_third  = out_third_ff;
   assign out_sat    = out_sat_ff;

endmodule

FILE: src/euler_frame_rotation_top.sv
// -----------------------------------------------------------------------------
// euler_frame_rotation_top - ZYX Euler frame rotation of three-axis vectors
// Holds roll, pitch and yaw, derives their trig coefficients, and rotates
// NED vectors to body axes or turns body rates into Euler angle rates.
// -----------------------------------------------------------------------------
// Usage:
//  - Write roll, pitch and yaw over the register port (byte addresses 0, 4
//    and 8, binary angle, pi/32768 rad per LSB). Each write restarts the
//    coefficient sequencer: a CORDIC run for each of roll, pitch and yaw and
//    then the matrix build, during which busy is high and no vector is taken.
//  - A vector transfer happens on a clock edge with start high and busy low.
//    While busy is low a new vector is taken every cycle.
//  - Each vector gives one result through three multiply, sum and tangent
//    stages, the divider's set-up stage and its 25 quotient stages, and the
//    output register. rsp_valid marks it for exactly one cycle; the receiver
//    cannot stall.
//  - rsp_saturated is high when any component was clipped to 24 bits,
//    which always happens in rate mode with a non-zero term at zero pitch
//    cosine.
//  - Reset clears the angles to zero and runs the coefficient sequencer,
//    so busy is also high after reset until the coefficients are built.
// -----------------------------------------------------------------------------
module euler_frame_rotation_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  efr_pkg::sample_type         req_in_first,
   input  efr_pkg::sample_type         req_in_second,
   input  efr_pkg::sample_type         req_in_third,
   output logic                        rsp_valid,
   output efr_pkg::sample_type         rsp_out_first,
   output efr_pkg::sample_type         rsp_out_second,
   output efr_pkg::sample_type         rsp_out_third,
   output logic                        rsp_saturated,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [efr_pkg::ADDR_W-1:0]  paddr,
   input  logic [efr_pkg::DATA_W-1:0]  pwdata,
   output logic [efr_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import efr_pkg::*;

   localparam int CW       = FRAC_BITS + 2;
   localparam int MW       = FRAC_BITS + 3;
   localparam int PIPE_LAT = QUO_BITS + 5;

   angle_type            roll_ff, pitch_ff, yaw_ff;
   logic                 csr_write;
   logic                 csr_hit;
   reg_idx_type          csr_idx;
   logic                 coef_busy;
   logic                 accept;
   logic signed [CW-1:0] sin_roll, cos_roll, sin_pitch, cos_pitch;
   logic signed [MW-1:0] mat [9];

   // Decode register transfers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = reg_idx_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         REG_ROLL:  begin csr_hit = 1'b1; prdata = {16'b0, roll_ff};  end
         REG_PITCH: begin csr_hit = 1'b1; prdata = {16'b0, pitch_ff}; end
         REG_YAW:   begin csr_hit = 1'b1; prdata = {16'b0, yaw_ff};   end
         default:   begin csr_hit = 1'b0; prdata = '0;                end
      endcase
   end

   // Hold the angle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff  <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_ROLL:  roll_ff  <= pwdata[ANGLE_W-1:0];
            REG_PITCH: pitch_ff <= pwdata[ANGLE_W-1:0];
            REG_YAW:   yaw_ff   <= pwdata[ANGLE_W-1:0];
            default:   ;
         endcase
      end
   end

   efr_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_write && csr_hit),
      .roll      (roll_ff),
      .pitch     (pitch_ff),
      .yaw       (yaw_ff),
      .busy      (coef_busy),
      .sin_roll  (sin_roll),
      .cos_roll  (cos_roll),
      .sin_pitch (sin_pitch),
      .cos_pitch (cos_pitch),
      .mat       (mat)
   );

   assign busy   = coef_busy;
   assign accept = start && !coef_busy;

   efr_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_mode    (req_mode),
      .in_a       (req_in_first),
      .in_b       (req_in_second),
      .in_c       (req_in_third),
      .sin_roll   (sin_roll),
      .cos_roll   (cos_roll),
      .sin_pitch  (sin_pitch),
      .cos_pitch  (cos_pitch),
      .mat        (mat),
      .out_valid  (rsp_valid),
      .out_first  (rsp_out_first),
      .out_second (rsp_out_second),
      .out_third  (rsp_out_third),
      .out_sat    (rsp_saturated)
   );

   // Every transfer comes out after the fixed pipeline depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_valid)
      else $error("result missing after pipeline latency");

   // A register write always restarts the coefficient sequencer
   a_restart : assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_hit) |=> busy)
      else $error("coefficient refresh not started");

   // A saturated result has a component at a range limit
   a_sat_edge : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_first == OUT_MAX || rsp_out_first == OUT_MIN ||
          rsp_out_second == OUT_MAX || rsp_out_second == OUT_MIN ||
          rsp_out_third == OUT_MAX || rsp_out_third == OUT_MIN))
      else $error("saturation flag without clipped component");

endmodule

FILE: dv/tb_euler_frame_rotation_top.sv
// -----------------------------------------------------------------------------
// tb_euler_frame_rotation_top - self-checking bench for the Euler frame rotation
// Programs roll, pitch and yaw over the register port, then streams NED vectors
// and body rates through the block. Each vector transfer is predicted in fixed
// point with a local CORDIC and compared field by field with the next result.
// -----------------------------------------------------------------------------
module tb_euler_frame_rotation_top;
   timeunit 1ns;
   timeprecision 1ps;

   import efr_pkg::*;

   localparam int  FRAC      = 16;
   localparam int  DRAIN     = 40;
   localparam int  NUM_SETS  = 10;
   localparam int  PER_SET   = 145;
   localparam longint HUGE_Q = longint'(1) <<< 40;

   typedef struct {
      logic       mode;
      sample_type v1, v2, v3;
   } vec_item_type;

   typedef struct {
      sample_type o1, o2, o3;
      logic       sat;
   } rot_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_mode = 1'b0;
   sample_type          req_in_first = '0;
   sample_type          req_in_second = '0;
   sample_type          req_in_third = '0;
   logic                rsp_valid;
   sample_type          rsp_out_first, rsp_out_second, rsp_out_third;
   logic                rsp_saturated;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   vec_item_type   vec_pending[$];
   rot_result_type rot_expected[$];
   int             errors = 0;
   int             idle_pct = 31;

   // current angles and their derived coefficients
   angle_type   ang_roll = '0, ang_pitch = '0, ang_yaw = '0;
   longint      sr, cr, sp, cp, sy, cy;

   euler_frame_rotation_top #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_in_first(req_in_first),
      .req_in_second(req_in_second), .req_in_third(req_in_third),
      .rsp_valid(rsp_valid), .rsp_out_first(rsp_out_first),
      .rsp_out_second(rsp_out_second), .rsp_out_third(rsp_out_third),
      .rsp_saturated(rsp_saturated), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   // rescale with rounding half toward plus infinity
   function automatic longint round_shift(input longint v, input int n);
      if (n == 0) return v;
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   // divide with rounding half away from zero; zero divisor blows up
   function automatic longint round_div(input longint n, input longint d);
      longint an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      if (ad == 0) return (n == 0) ? 0 : ((n < 0) ? -HUGE_Q : HUGE_Q);
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic sample_type clip_out(input longint v, inout logic flag);
      if (v > 8388607) begin
         flag = 1'b1;
         return OUT_MAX;
      end
      if (v < -8388608) begin
         flag = 1'b1;
         return OUT_MIN;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // fold beyond ninety degrees, then 30 CORDIC micro-rotations
   task automatic sin_cos(input angle_type ang, output longint sn, output longint cs);
      longint z, x, y, nx;
      bit     neg;
      z   = longint'(ang) <<< 16;
      x   = 652032874;
      y   = 0;
      neg = 0;
      if (z > (longint'(1) <<< 30)) begin
         z   = z - (longint'(1) <<< 31);
         neg = 1;
      end else if (z < -(longint'(1) <<< 30)) begin
         z   = z + (longint'(1) <<< 31);
         neg = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      sn = round_shift(y, 30 - FRAC);
      cs = round_shift(x, 30 - FRAC);
   endtask

   task automatic refresh_coeffs();
      sin_cos(ang_roll, sr, cr);
      sin_cos(ang_pitch, sp, cp);
      sin_cos(ang_yaw, sy, cy);
   endtask

   function automatic longint fmul(input longint a, input longint b);
      return round_shift(a * b, FRAC);
   endfunction

   // expected body vector or Euler rates for one vector transfer
   function automatic rot_result_type rotate_vector(input vec_item_type it);
      rot_result_type r;
      longint a, b, c, r0, r1, r2, t;
      longint cysp, sysp, m11, m12, m13, m21, m22, m23, m31, m32, m33;
      logic   flag;
      a = it.v1;
      b = it.v2;
      c = it.v3;
      flag = 1'b0;
      if (it.mode == 1'b0) begin
         cysp = fmul(cy, sp);
         sysp = fmul(sy, sp);
         m11 = fmul(cy, cp);
         m12 = fmul(sy, cp);
         m13 = -sp;
         m21 = fmul(cysp, sr) - fmul(sy, cr);
         m22 = fmul(sysp, sr) + fmul(cy, cr);
         m23 = fmul(cp, sr);
         m31 = fmul(cysp, cr) + fmul(sy, sr);
         m32 = fmul(sysp, cr) - fmul(cy, sr);
         m33 = fmul(cp, cr);
         r0 = round_shift(m11 * a + m12 * b + m13 * c, FRAC);
         r1 = round_shift(m21 * a + m22 * b + m23 * c, FRAC);
         r2 = round_shift(m31 * a + m32 * b + m33 * c, FRAC);
      end else begin
         t  = round_shift(cr * c - sr * b, FRAC);
         r0 = a + round_div(t * sp, cp);
         r1 = round_shift(cr * b - sr * c, FRAC);
         r2 = round_div(sr * b + cr * c, cp);
      end
      r.o1  = clip_out(r0, flag);
      r.o2  = clip_out(r1, flag);
      r.o3  = clip_out(r2, flag);
      r.sat = flag;
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // write one angle register: setup then access cycle
   task automatic write_angle(input reg_idx_type idx, input angle_type val);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'(4 * int'(idx));
      pwdata  <= DATA_W'($unsigned(val));
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ROLL:  ang_roll = val;
         REG_PITCH: ang_pitch = val;
         default:   ang_yaw = val;
      endcase
      refresh_coeffs();
   endtask

   task automatic queue_vec(input logic m, input longint x, input longint y, input longint z);
      vec_item_type it;
      it.mode = m;
      it.v1   = x[SAMPLE_W-1:0];
      it.v2   = y[SAMPLE_W-1:0];
      it.v3   = z[SAMPLE_W-1:0];
      vec_pending.push_back(it);
   endtask

   function automatic longint rand_comp();
      if ($urandom_range(1)) return longint'($signed(24'($urandom)));
      return longint'($urandom_range(524288)) - 262144;
   endfunction

   // driver: hold start until the transfer, then advance to the next vector
   always @(posedge clock) begin : drive_proc
      logic         nxt;
      vec_item_type it;
      nxt = start;
      if (start && !busy) begin
         it.mode = req_mode;
         it.v1   = req_in_first;
         it.v2   = req_in_second;
         it.v3   = req_in_third;
         rot_expected.push_back(rotate_vector(it));
         nxt = 1'b0;
      end
      if (!nxt && vec_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
         it = vec_pending.pop_front();
         req_mode      <= it.mode;
         req_in_first  <= it.v1;
         req_in_second <= it.v2;
         req_in_third  <= it.v3;
         nxt = 1'b1;
      end
      start <= nxt;
   end

   // monitor: check each result transfer against the oldest prediction
   always @(posedge clock) begin : check_proc
      rot_result_type e;
      if (!reset && rsp_valid) begin
         if (rot_expected.size() == 0) begin
            report("unexpected result", 1, 0);
         end else begin
            e = rot_expected.pop_front();
            if (rsp_out_first !== e.o1)  report("out_first", rsp_out_first, e.o1);
            if (rsp_out_second !== e.o2) report("out_second", rsp_out_second, e.o2);
            if (rsp_out_third !== e.o3)  report("out_third", rsp_out_third, e.o3);
            if (rsp_saturated !== e.sat) report("saturated", rsp_saturated, e.sat);
         end
      end
   end

   task automatic drain();
      while (vec_pending.size() > 0 || start || rot_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      angle_type sets [NUM_SETS][3];
      sets = '{'{16'sd0, 16'sd16384, 16'sd0}, '{16'sd8192, -16'sd16384, 16'sd4096},
               '{16'sd32767, -16'sd32768, 16'sd32767},
               '{-16'sd32768, 16'sd32767, -16'sd32768},
               '{16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0},
               '{16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0},
               '{16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0}};
      refresh_coeffs();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes at reset angles
      queue_vec(0, 8388607, 8388607, 8388607);
      queue_vec(0, -8388608, -8388608, -8388608);
      queue_vec(1, 8388607, -8388608, 8388607);
      queue_vec(1, -8388608, 8388607, -8388608);
      queue_vec(0, 0, 0, 0);
      queue_vec(1, 65536, 65536, 65536);
      queue_vec(0, 65536, -65536, 32768);
      queue_vec(1, -1, 1, -1);
      drain();

      for (int s = 0; s < NUM_SETS; s++) begin
         if (s >= 4)
            for (int k = 0; k < 3; k++) sets[s][k] = angle_type'($urandom);
         write_angle(REG_ROLL, sets[s][0]);
         write_angle(REG_PITCH, sets[s][1]);
         write_angle(REG_YAW, sets[s][2]);
         // pitch straight up or down: zero and non-zero rate terms
         if (s < 2) begin
            queue_vec(1, 12345, 0, 0);
            queue_vec(1, 0, 65536, 0);
            queue_vec(1, 0, 0, -65536);
            queue_vec(1, 8388607, 0, 0);
            queue_vec(0, 65536, 65536, 65536);
         end
         idle_pct = (s == 3) ? 0 : 31;
         for (int n = 0; n < PER_SET; n++)
            queue_vec($urandom_range(1), rand_comp(), rand_comp(), rand_comp());
         drain();
      end

      if (errors == 0)
         $display("euler_frame_rotation_top verification clean");
      else
         $display("euler_frame_rotation_top verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("euler_frame_rotation_top verification failed");
      $finish;
   end

endmodule
